[hdl/mtg_pkg.sv]
package mtg_pkg;

   localparam int STATE_DEPTH   = 312;
   localparam int TWIST_OFFSET  = 156;
   localparam int MAX_KEY_WORDS = 312;

   localparam int IDX_W = 9;
   localparam int KEY_W = 9;

   localparam logic [1:0] OP_SEED = 2'd0;
   localparam logic [1:0] OP_NEXT = 2'd1;
   localparam logic [1:0] OP_KEY  = 2'd2;

   localparam logic [IDX_W-1:0] NOT_SEEDED = IDX_W'(STATE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(STATE_DEPTH - 1);

   localparam logic [63:0] MATRIX_A   = 64'hB5026F5AA96619E9;
   localparam logic [63:0] UPPER_MASK = 64'hFFFFFFFF80000000;
   localparam logic [63:0] LOWER_MASK = 64'h000000007FFFFFFF;
   localparam logic [63:0] SEED_MULT  = 64'd6364136223846793005;
   localparam logic [63:0] INIT_MULT1 = 64'd3935559000370003845;
   localparam logic [63:0] INIT_MULT2 = 64'd2862933555777941757;
   localparam logic [63:0] INIT_SEED  = 64'd19650218;
   localparam logic [63:0] DFLT_SEED  = 64'd5489;

   // Datapath commands issued by the controller.
   localparam logic [3:0] DP_NOP      = 4'd0;
   localparam logic [3:0] DP_RD_A     = 4'd1;  // latch read word into a
   localparam logic [3:0] DP_RD_B     = 4'd2;  // latch read word into b
   localparam logic [3:0] DP_RD_C     = 4'd3;  // latch read word into c
   localparam logic [3:0] DP_MUL      = 4'd4;  // low halves of prev word and constant
   localparam logic [3:0] DP_WR_SEED  = 4'd5;  // write prod + index
   localparam logic [3:0] DP_WR_INIT1 = 4'd6;  // write (cur ^ prod) + key + j
   localparam logic [3:0] DP_WR_INIT2 = 4'd7;  // write (cur ^ prod) - i
   localparam logic [3:0] DP_WR_MIX   = 4'd8;  // write twist mix of a, b, c
   localparam logic [3:0] DP_WR_VAL   = 4'd9;  // write the seed value, a constant or a copy
   localparam logic [3:0] DP_OUT      = 4'd10; // temper a and present it
   localparam logic [3:0] DP_KEY_WR   = 4'd11; // store key word
   localparam logic [3:0] DP_MUL_LH   = 4'd12; // add low word times high constant
   localparam logic [3:0] DP_MUL_HL   = 4'd13; // add high word times low constant

   // Multiplier constant select.
   localparam logic [1:0] MUL_SEED  = 2'd0;
   localparam logic [1:0] MUL_INIT1 = 2'd1;
   localparam logic [1:0] MUL_INIT2 = 2'd2;

   // Write value select.
   localparam logic [1:0] VAL_SEED = 2'd0;
   localparam logic [1:0] VAL_COPY = 2'd1;
   localparam logic [1:0] VAL_TOP  = 2'd2;

   typedef struct packed {
      logic [3:0]       op;
      logic [IDX_W-1:0] addr;
      logic [KEY_W-1:0] key_addr;
      logic [1:0]       mult_sel;
      logic [1:0]       val_sel;
   } dp_cmd_type;

endpackage

[hdl/mtg_datapath.sv]
module mtg_datapath
   import mtg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   input  logic [63:0] seed_value,
   input  logic [63:0] key_value,
   output logic [63:0] random_value,
   output logic        random_strobe
);

   logic [63:0] mem [STATE_DEPTH];
   logic [63:0] keys [MAX_KEY_WORDS];
   logic [63:0] rd_ff;
   logic [63:0] key_rd_ff;
   logic [63:0] a_ff, b_ff, c_ff, prod_ff;
   logic [63:0] out_ff;
   logic        strobe_ff;
   logic [63:0] mul_src, mul_k, wr_data, y, t0, t1, t2, t3;
   logic [31:0] mul_x, mul_y;
   logic [63:0] pp;
   logic        wr_en;

   always_comb begin
      mul_src = a_ff ^ (a_ff >> 62);
      case (cmd.mult_sel)
         MUL_INIT1: mul_k = INIT_MULT1;
         MUL_INIT2: mul_k = INIT_MULT2;
         default:   mul_k = SEED_MULT;
      endcase
      // The low 64 bits of the product are built from three 32 by 32 passes.
      case (cmd.op)
         DP_MUL_LH: begin
            mul_x = mul_src[31:0];
            mul_y = mul_k[63:32];
         end
         DP_MUL_HL: begin
            mul_x = mul_src[63:32];
            mul_y = mul_k[31:0];
         end
         default: begin
            mul_x = mul_src[31:0];
            mul_y = mul_k[31:0];
         end
      endcase
      pp = 64'(mul_x) * 64'(mul_y);
      y = (a_ff & UPPER_MASK) | (b_ff & LOWER_MASK);
      wr_en = 1'b1;
      case (cmd.op)
         DP_WR_SEED:  wr_data = prod_ff + 64'(cmd.addr);
         DP_WR_INIT1: wr_data = (b_ff ^ prod_ff) + key_rd_ff + 64'(cmd.key_addr);
         DP_WR_INIT2: wr_data = (b_ff ^ prod_ff) - 64'(cmd.addr);
         DP_WR_MIX:   wr_data = c_ff ^ (y >> 1) ^ (y[0] ? MATRIX_A : 64'd0);
         DP_WR_VAL: begin
            case (cmd.val_sel)
               VAL_COPY: wr_data = b_ff;
               VAL_TOP:  wr_data = 64'h8000000000000000;
               default:  wr_data = seed_value;
            endcase
         end
         default: begin
            wr_data = 64'd0;
            wr_en = 1'b0;
         end
      endcase
      t0 = a_ff ^ ((a_ff >> 29) & 64'h5555555555555555);
      t1 = t0 ^ ((t0 << 17) & 64'h71D67FFFEDA60000);
      t2 = t1 ^ ((t1 << 37) & 64'hFFF7EEE000000000);
      t3 = t2 ^ (t2 >> 43);
   end

   // The read port follows the command address every cycle; the data lands in the cycle after.
   always_ff @(posedge clock) begin
      rd_ff     <= mem[cmd.addr];
      key_rd_ff <= keys[cmd.key_addr];
      if (wr_en) mem[cmd.addr] <= wr_data;
      if (cmd.op == DP_KEY_WR) keys[cmd.key_addr] <= key_value;
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_RD_A:   a_ff <= rd_ff;
         DP_RD_B:   b_ff <= rd_ff;
         DP_RD_C:   c_ff <= rd_ff;
         DP_MUL:    prod_ff <= pp;
         DP_MUL_LH: prod_ff <= prod_ff + {pp[31:0], 32'd0};
         DP_MUL_HL: prod_ff <= prod_ff + {pp[31:0], 32'd0};
         default: ;
      endcase
      if (cmd.op == DP_OUT) out_ff <= t3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (cmd.op == DP_OUT);
      end
   end

   assign random_value  = out_ff;
   assign random_strobe = strobe_ff;

endmodule

[hdl/mtg_control.sv]
module mtg_control
   import mtg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  op,
   input  logic        last_key,
   output logic        busy,
   output dp_cmd_type  cmd
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_SD_W0  = 5'd1;
   localparam logic [4:0] S_SD_RD  = 5'd2;
   localparam logic [4:0] S_SD_LA  = 5'd3;
   localparam logic [4:0] S_SD_MUL = 5'd4;
   localparam logic [4:0] S_SD_WR  = 5'd5;
   localparam logic [4:0] S_TW_RA  = 5'd6;
   localparam logic [4:0] S_TW_RB  = 5'd7;
   localparam logic [4:0] S_TW_RC  = 5'd8;
   localparam logic [4:0] S_TW_LC  = 5'd11;
   localparam logic [4:0] S_TW_WR  = 5'd12;
   localparam logic [4:0] S_OUT_RD = 5'd13;
   localparam logic [4:0] S_OUT_LA = 5'd14;
   localparam logic [4:0] S_OUT_GO = 5'd15;
   localparam logic [4:0] S_AI_RP  = 5'd16;
   localparam logic [4:0] S_AI_RC  = 5'd17;
   localparam logic [4:0] S_AI_LA  = 5'd18;
   localparam logic [4:0] S_AI_LB  = 5'd19;
   localparam logic [4:0] S_AI_MUL = 5'd20;
   localparam logic [4:0] S_AI_WR  = 5'd21;
   localparam logic [4:0] S_CP_RD  = 5'd22;
   localparam logic [4:0] S_CP_LB  = 5'd23;
   localparam logic [4:0] S_CP_WR  = 5'd24;
   localparam logic [4:0] S_AI_TOP = 5'd25;
   localparam logic [4:0] S_SD_MLH = 5'd26;
   localparam logic [4:0] S_SD_MHL = 5'd27;
   localparam logic [4:0] S_AI_MLH = 5'd28;
   localparam logic [4:0] S_AI_MHL = 5'd29;

   logic [4:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;         // read index
   logic [IDX_W-1:0] n_ff, n_in;             // loop position
   logic [KEY_W-1:0] kc_ff, kc_in;           // key count
   logic [KEY_W-1:0] j_ff, j_in;
   logic [10:0]      k_ff, k_in;             // iteration count
   logic             ph2_ff, ph2_in;         // second init phase
   logic [1:0]       after_ff, after_in;     // 0 idle, 1 twist, 2 array init
   logic             next_ff, next_in;       // output follows twist

   localparam logic [1:0] AFT_IDLE  = 2'd0;
   localparam logic [1:0] AFT_TWIST = 2'd1;
   localparam logic [1:0] AFT_INIT  = 2'd2;

   assign busy = (state_ff != S_IDLE);

   function automatic logic [IDX_W-1:0] far_addr(input logic [IDX_W-1:0] n);
      logic [IDX_W:0] s;
      s = {1'b0, n} + (IDX_W+1)'(TWIST_OFFSET);
      if (s >= (IDX_W+1)'(STATE_DEPTH)) s = s - (IDX_W+1)'(STATE_DEPTH);
      return s[IDX_W-1:0];
   endfunction

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      n_in     = n_ff;
      kc_in    = kc_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      ph2_in   = ph2_ff;
      after_in = after_ff;
      next_in  = next_ff;
      cmd      = '0;
      cmd.op   = DP_NOP;
      cmd.key_addr = j_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (op)
                  OP_SEED: begin
                     cmd.op = DP_WR_VAL;
                     cmd.addr = '0;
                     cmd.val_sel = VAL_SEED;
                     n_in = IDX_W'(1);
                     after_in = AFT_IDLE;
                     state_in = S_SD_RD;
                  end
                  OP_NEXT: begin
                     next_in = 1'b1;
                     if (idx_ff == NOT_SEEDED) begin
                        after_in = AFT_TWIST;
                        state_in = S_SD_W0;
                     end else if (idx_ff == IDX_W'(STATE_DEPTH)) begin
                        n_in = '0;
                        state_in = S_TW_RA;
                     end else begin
                        state_in = S_OUT_RD;
                     end
                  end
                  OP_KEY: begin
                     if (kc_ff < KEY_W'(MAX_KEY_WORDS)) begin
                        cmd.op = DP_KEY_WR;
                        cmd.key_addr = kc_ff;
                        kc_in = kc_ff + KEY_W'(1);
                     end
                     if (last_key) begin
                        after_in = AFT_INIT;
                        state_in = S_SD_W0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // Seeding: write word 0, then for each further word read the previous one, multiply and write.
         S_SD_W0: begin
            cmd.op = DP_WR_VAL;
            cmd.addr = '0;
            cmd.val_sel = VAL_SEED;
            n_in = IDX_W'(1);
            state_in = S_SD_RD;
         end
         S_SD_RD: begin
            cmd.addr = n_ff - IDX_W'(1);
            state_in = S_SD_LA;
         end
         S_SD_LA: begin
            cmd.op = DP_RD_A;
            state_in = S_SD_MUL;
         end
         S_SD_MUL: begin
            cmd.op = DP_MUL;
            cmd.mult_sel = MUL_SEED;
            state_in = S_SD_MLH;
         end
         S_SD_MLH: begin
            cmd.op = DP_MUL_LH;
            cmd.mult_sel = MUL_SEED;
            state_in = S_SD_MHL;
         end
         S_SD_MHL: begin
            cmd.op = DP_MUL_HL;
            cmd.mult_sel = MUL_SEED;
            state_in = S_SD_WR;
         end
         S_SD_WR: begin
            cmd.op = DP_WR_SEED;
            cmd.addr = n_ff;
            if (n_ff == LAST_IDX) begin
               idx_in = IDX_W'(STATE_DEPTH);
               unique case (after_ff)
                  AFT_TWIST: begin
                     n_in = '0;
                     state_in = S_TW_RA;
                  end
                  AFT_INIT: begin
                     n_in = IDX_W'(1);
                     j_in = '0;
                     ph2_in = 1'b0;
                     k_in = (kc_ff > KEY_W'(STATE_DEPTH)) ? 11'(kc_ff) : 11'(STATE_DEPTH);
                     state_in = S_AI_RP;
                  end
                  default: state_in = S_IDLE;
               endcase
            end else begin
               n_in = n_ff + IDX_W'(1);
               state_in = S_SD_RD;
            end
         end
         // Twist: read n, n+1 and the far word, then write n.
         S_TW_RA: begin
            cmd.addr = n_ff;
            state_in = S_TW_RB;
         end
         S_TW_RB: begin
            cmd.op = DP_RD_A;
            cmd.addr = (n_ff == LAST_IDX) ? '0 : n_ff + IDX_W'(1);
            state_in = S_TW_RC;
         end
         S_TW_RC: begin
            cmd.op = DP_RD_B;
            cmd.addr = far_addr(n_ff);
            state_in = S_TW_LC;
         end
         S_TW_LC: begin
            cmd.op = DP_RD_C;
            state_in = S_TW_WR;
         end
         S_TW_WR: begin
            cmd.op = DP_WR_MIX;
            cmd.addr = n_ff;
            if (n_ff == LAST_IDX) begin
               idx_in = '0;
               state_in = next_ff ? S_OUT_RD : S_IDLE;
            end else begin
               n_in = n_ff + IDX_W'(1);
               state_in = S_TW_RA;
            end
         end
         S_OUT_RD: begin
            cmd.addr = idx_ff;
            state_in = S_OUT_LA;
         end
         S_OUT_LA: begin
            cmd.op = DP_RD_A;
            state_in = S_OUT_GO;
         end
         S_OUT_GO: begin
            cmd.op = DP_OUT;
            idx_in = idx_ff + IDX_W'(1);
            next_in = 1'b0;
            state_in = S_IDLE;
         end
         // Array initialization: a = word i-1, b = word i, product, write.
         S_AI_RP: begin
            cmd.addr = n_ff - IDX_W'(1);
            state_in = S_AI_RC;
         end
         S_AI_RC: begin
            cmd.op = DP_RD_A;
            cmd.addr = n_ff;
            state_in = S_AI_LB;
         end
         S_AI_LB: begin
            cmd.op = DP_RD_B;
            state_in = S_AI_MUL;
         end
         S_AI_MUL: begin
            cmd.op = DP_MUL;
            cmd.mult_sel = ph2_ff ? MUL_INIT2 : MUL_INIT1;
            state_in = S_AI_MLH;
         end
         S_AI_MLH: begin
            cmd.op = DP_MUL_LH;
            cmd.mult_sel = ph2_ff ? MUL_INIT2 : MUL_INIT1;
            state_in = S_AI_MHL;
         end
         S_AI_MHL: begin
            cmd.op = DP_MUL_HL;
            cmd.mult_sel = ph2_ff ? MUL_INIT2 : MUL_INIT1;
            state_in = S_AI_WR;
         end
         S_AI_WR: begin
            cmd.op = ph2_ff ? DP_WR_INIT2 : DP_WR_INIT1;
            cmd.addr = n_ff;
            cmd.key_addr = j_ff;
            if (!ph2_ff) j_in = (j_ff + KEY_W'(1) >= kc_ff) ? '0 : j_ff + KEY_W'(1);
            k_in = k_ff - 11'd1;
            if (n_ff == LAST_IDX) begin
               n_in = IDX_W'(1);
               state_in = S_CP_RD;
            end else begin
               n_in = n_ff + IDX_W'(1);
               state_in = S_AI_LA;
            end
         end
         S_AI_LA: begin
            if (k_ff == 11'd0) begin
               if (ph2_ff) begin
                  state_in = S_AI_TOP;
               end else begin
                  ph2_in = 1'b1;
                  k_in = 11'(STATE_DEPTH - 1);
                  state_in = S_AI_RP;
               end
            end else begin
               state_in = S_AI_RP;
            end
         end
         // Copy the last word to word 0 at wraparound.
         S_CP_RD: begin
            cmd.addr = LAST_IDX;
            state_in = S_CP_LB;
         end
         S_CP_LB: begin
            cmd.op = DP_RD_B;
            state_in = S_CP_WR;
         end
         S_CP_WR: begin
            cmd.op = DP_WR_VAL;
            cmd.addr = '0;
            cmd.val_sel = VAL_COPY;
            state_in = S_AI_LA;
         end
         S_AI_TOP: begin
            cmd.op = DP_WR_VAL;
            cmd.addr = '0;
            cmd.val_sel = VAL_TOP;
            kc_in = '0;
            idx_in = IDX_W'(STATE_DEPTH);
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= NOT_SEEDED;
         kc_ff    <= '0;
         next_ff  <= 1'b0;
         after_ff <= AFT_IDLE;
         ph2_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         kc_ff    <= kc_in;
         next_ff  <= next_in;
         after_ff <= after_in;
         ph2_ff   <= ph2_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      j_ff <= j_in;
      k_ff <= k_in;
   end

endmodule

[hdl/mersenne_twister_64_generator_unit.sv]
// Channel  | Ports                                  | Transfer
// request  | start, busy, req_op, req_value,        | start high while busy low
//          | req_last_key                           |
// response | rsp_strobe, rsp_random_value           | every cycle rsp_strobe is high
//
// A next from a ready state puts its word out as busy drops; an exhausted index first
// regenerates all 312 words. A seed walks 311 words; a final key word runs the seed with
// the fixed init value and then 623 update steps, with a copy of the last word to word 0
// where the index wraps. Reset clears the controller and marks the state unseeded.
// Results cannot be stalled by the receiver; busy holds new requests off.
module mersenne_twister_64_generator_unit
   import mtg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_value,
   input  logic        req_last_key,
   output logic        rsp_strobe,
   output logic [63:0] rsp_random_value
);

   dp_cmd_type  cmd;
   logic [63:0] seed_sel;
   logic [1:0]  req_op_ff;

   always_ff @(posedge clock) begin
      if (start && !busy) req_op_ff <= req_op;
   end

   // The seed source: the request value, the array-init constant or the default.
   always_comb begin
      if (start && !busy) seed_sel = (req_op == OP_SEED) ? req_value : INIT_SEED;
      else if (req_op_ff == OP_NEXT) seed_sel = DFLT_SEED;
      else seed_sel = INIT_SEED;
   end

   mtg_control u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .op       (req_op),
      .last_key (req_last_key),
      .busy     (busy),
      .cmd      (cmd)
   );

   mtg_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .seed_value    (seed_sel),
      .key_value     (req_value),
      .random_value  (rsp_random_value),
      .random_strobe (rsp_strobe)
   );

endmodule

[tb/mersenne_twister_64_generator_checker.sv]
`timescale 1ns / 1ps

module mersenne_twister_64_generator_checker
   import mtg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_value,
   input  logic        req_last_key,
   input  logic        rsp_strobe,
   input  logic [63:0] rsp_random_value,
   output int          error_count,
   output int          words_pending,
   output int          words_checked,
   output int          inits_seen
);

   localparam logic [63:0] TEMPER_MASK_B = 64'h5555555555555555;
   localparam logic [63:0] TEMPER_MASK_C = 64'h71D67FFFEDA60000;
   localparam logic [63:0] TEMPER_MASK_D = 64'hFFF7EEE000000000;

   logic [63:0] mt_words [STATE_DEPTH];
   logic [63:0] key_words [MAX_KEY_WORDS];
   int          mt_index;
   int          key_len;
   logic [63:0] expected_words [$];

   function automatic void seed_words(input logic [63:0] s);
      logic [63:0] p;
      mt_words[0] = s;
      for (int n = 1; n < STATE_DEPTH; n++) begin
         p = mt_words[n-1];
         mt_words[n] = SEED_MULT * (p ^ (p >> 62)) + 64'(n);
      end
      mt_index = STATE_DEPTH;
   endfunction

   function automatic void key_init(input int len);
      int i;
      int j;
      int k;
      logic [63:0] p;
      i = 1;
      j = 0;
      seed_words(INIT_SEED);
      k = (STATE_DEPTH > len) ? STATE_DEPTH : len;
      for (; k > 0; k--) begin
         p = mt_words[i-1];
         mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 62)) * INIT_MULT1)) + key_words[j] + 64'(j);
         i++;
         if (i >= STATE_DEPTH) begin
            mt_words[0] = mt_words[STATE_DEPTH-1];
            i = 1;
         end
         j++;
         if (j >= len) j = 0;
      end
      for (k = STATE_DEPTH - 1; k > 0; k--) begin
         p = mt_words[i-1];
         mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 62)) * INIT_MULT2)) - 64'(i);
         i++;
         if (i >= STATE_DEPTH) begin
            mt_words[0] = mt_words[STATE_DEPTH-1];
            i = 1;
         end
      end
      mt_words[0] = 64'h8000000000000000;
   endfunction

   function automatic logic [63:0] mix(input logic [63:0] hi, input logic [63:0] lo,
                                       input logic [63:0] far);
      logic [63:0] y;
      y = (hi & UPPER_MASK) | (lo & LOWER_MASK);
      return far ^ (y >> 1) ^ (y[0] ? MATRIX_A : 64'd0);
   endfunction

   function automatic void regenerate();
      for (int n = 0; n < STATE_DEPTH; n++)
         mt_words[n] = mix(mt_words[n], mt_words[(n + 1) % STATE_DEPTH],
                           mt_words[(n + TWIST_OFFSET) % STATE_DEPTH]);
      mt_index = 0;
   endfunction

   function automatic logic [63:0] draw_word();
      logic [63:0] x;
      if (mt_index >= STATE_DEPTH) begin
         if (mt_index > STATE_DEPTH) seed_words(DFLT_SEED);
         regenerate();
      end
      x = mt_words[mt_index];
      mt_index++;
      x ^= (x >> 29) & TEMPER_MASK_B;
      x ^= (x << 17) & TEMPER_MASK_C;
      x ^= (x << 37) & TEMPER_MASK_D;
      x ^= (x >> 43);
      return x;
   endfunction

   assign words_pending = expected_words.size();

   always @(posedge clock) begin
      if (reset) begin
         mt_index = STATE_DEPTH + 1;
         key_len = 0;
         expected_words.delete();
         error_count <= 0;
         words_checked <= 0;
         inits_seen <= 0;
      end else begin
         // Results are checked before this edge's request, which is always older.
         if (rsp_strobe) begin
            if (expected_words.size() == 0) begin
               $error("rsp_random_value: unexpected result %h", rsp_random_value);
               error_count <= error_count + 1;
            end else begin
               if (rsp_random_value !== expected_words[0]) begin
                  $error("rsp_random_value: expected %h, actual %h",
                         expected_words[0], rsp_random_value);
                  error_count <= error_count + 1;
               end
               void'(expected_words.pop_front());
               words_checked <= words_checked + 1;
            end
         end
         if (start && !busy) begin
            case (req_op)
               OP_SEED: seed_words(req_value);
               OP_NEXT: expected_words.push_back(draw_word());
               OP_KEY: begin
                  if (key_len < MAX_KEY_WORDS) begin
                     key_words[key_len] = req_value;
                     key_len++;
                  end
                  if (req_last_key) begin
                     key_init(key_len);
                     key_len = 0;
                     inits_seen <= inits_seen + 1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

endmodule

[tb/mersenne_twister_64_generator_unit_tb.sv]
`timescale 1ns / 1ps

module mersenne_twister_64_generator_unit_tb;
   import mtg_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 8000;
   localparam int ITEM_TARGET = 1150;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_op;
   logic [63:0] req_value;
   logic        req_last_key;
   logic        rsp_strobe;
   logic [63:0] rsp_random_value;
   int          error_count;
   int          words_pending;
   int          words_checked;
   int          inits_seen;
   int          cycle_count;
   int          burst_left;
   int          items_sent;

   mersenne_twister_64_generator_unit dut (.*);

   mersenne_twister_64_generator_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Drives one request and holds it until the transfer happens. Between bursts
   // start may drop for a random number of cycles.
   task automatic send_item(input logic [1:0] op, input logic [63:0] v, input logic lk);
      if (burst_left == 0) begin
         start = 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      start = 1'b1;
      req_op = op;
      req_value = v;
      req_last_key = lk;
      do @(posedge clock); while (busy);
      @(negedge clock);
      burst_left--;
      items_sent++;
   endtask

   initial begin
      int kind;
      int n;
      start = 1'b0;
      reset = 1'b1;
      req_op = OP_SEED;
      req_value = '0;
      req_last_key = 1'b0;
      burst_left = 0;
      items_sent = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed: default seeding, ignored codes and flags, extreme seeds and keys.
      send_item(OP_NEXT, 64'd0, 1'b1);
      send_item(OP_NEXT, '1, 1'b0);
      send_item(OP_UNUSED, '1, 1'b1);
      send_item(OP_NEXT, 64'd0, 1'b0);
      send_item(OP_SEED, 64'd0, 1'b1);
      send_item(OP_NEXT, 64'd0, 1'b0);
      send_item(OP_SEED, '1, 1'b0);
      send_item(OP_NEXT, 64'd0, 1'b0);
      send_item(OP_KEY, 64'd0, 1'b1);
      send_item(OP_NEXT, 64'd0, 1'b0);
      send_item(OP_KEY, '1, 1'b1);
      send_item(OP_NEXT, 64'd0, 1'b0);
      send_item(OP_KEY, 64'h0123456789ABCDEF, 1'b0);
      send_item(OP_SEED, 64'h5555AAAA5555AAAA, 1'b0);
      send_item(OP_NEXT, 64'd0, 1'b0);
      send_item(OP_KEY, 64'hFEDCBA9876543210, 1'b1);
      send_item(OP_NEXT, 64'd0, 1'b0);
      send_item(OP_UNUSED, 64'd0, 1'b0);
      send_item(OP_NEXT, 64'd0, 1'b0);

      // One key that overflows the store, with the final word beyond capacity.
      for (int i = 0; i < MAX_KEY_WORDS + 3; i++)
         send_item(OP_KEY, rand64(), i == MAX_KEY_WORDS + 2);
      send_item(OP_NEXT, 64'd0, 1'b0);

      while (items_sent < ITEM_TARGET) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 330) : $urandom_range(1, 8);
            for (int i = 0; i < n && items_sent < ITEM_TARGET; i++)
               send_item(OP_NEXT, rand64(), 1'($urandom_range(0, 1)));
         end else if (kind < 80) begin
            send_item(OP_SEED, rand64(), 1'($urandom_range(0, 1)));
         end else if (kind < 97) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) send_item(OP_KEY, rand64(), i == n - 1);
         end else begin
            send_item($urandom_range(0, 4) == 0 ? OP_UNUSED : OP_KEY, rand64(), 1'b0);
         end
      end
      start = 1'b0;

      while (words_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d requests; checked %0d output words across %0d key initializations.",
               items_sent, words_checked, inits_seen);
      if (error_count == 0 && words_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
